FILE: sv/cic_pkg.sv
// Shared types, widths and codes for the cloud-in-cell deposit unit.
// No dependencies; every other file in this block but cic_ram imports it.
package cic_pkg;

    localparam int POS_W      = 32;
    localparam int INV_W      = 24;
    localparam int SIZE_REG_W = 6;
    localparam int CHG_W      = 32;
    localparam int ACC_W      = 48;
    localparam int IDX_IN_W   = 15;
    localparam int STAT_W     = 2;
    localparam int FRAC_W     = 16;
    localparam int WGT_W      = 17;   // Q1.16, up to 1.0
    localparam int SZ_W       = 9;    // effective size, up to 256
    localparam int CI_W       = 8;    // cell coordinate, below 256
    localparam int PROD_W     = POS_W + INV_W;
    localparam int CTRB_W     = CHG_W + WGT_W + 1 - FRAC_W;
    localparam int SUM_W      = ACC_W + 2;
    localparam int S_TDATA_W  = 144;
    localparam int M_TDATA_W  = 56;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Z = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_X  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_Y  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_Z  = 3'd5;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_RANGE = 2'd1,
        STAT_SAT   = 2'd2
    } cic_stat_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SPLIT,
        ST_CHECK,
        ST_C_ADDR,
        ST_C_WGT,
        ST_C_READ,
        ST_C_WRITE,
        ST_RD_ADDR,
        ST_RD_DATA,
        ST_FINISH
    } cic_state_t;

    typedef struct packed {
        logic in_ready;
        logic accept;
        logic clear;
        logic split;
        logic check;
        logic c_addr;
        logic c_wgt;
        logic c_read;
        logic c_write;
        logic rd_addr;
        logic rd_data;
        logic out_load;
    } cic_cmd_t;

    typedef struct packed {
        logic clr_done;
        logic is_read;
        logic range_fail;
        logic last_corner;
    } cic_sts_t;

    // Clamp a size register to 1..maxv.
    function automatic logic [SZ_W-1:0] eff_size(logic [SIZE_REG_W-1:0] s,
                                                 logic [SZ_W-1:0] maxv);
        logic [SZ_W-1:0] ext;
        ext = SZ_W'(s);
        if (ext == '0) begin
            return SZ_W'(1);
        end
        if (ext > maxv) begin
            return maxv;
        end
        return ext;
    endfunction

endpackage

FILE: sv/cloud_in_cell_deposit_unit.sv
// Cloud-in-cell deposit unit: spreads each particle's charge over the eight
// surrounding cells of a periodic 3D grid of saturating Q32.16 accumulators
// held in one single-port memory, and reads single cells back. After reset
// the unit first clears all MAX_CELLS_X * MAX_CELLS_Y * MAX_CELLS_Z cells
// (32768 at the defaults), one cell a cycle, with s_tready low; configuration
// writes are taken during that pass. An accepted deposit runs a split and a
// range check, then per corner an address, weight, memory read and memory
// write step on the one grid port, then the output load. A deposit out of
// range goes from the check to the output load; a read runs the split, a read
// address and a read data step, then the load. The next request can be taken
// in the cycle after the load; a full output register holds the load until
// the waiting result is taken. One item is in work at a time; the next is
// accepted while a result waits in the output register.
// Depends on cic_pkg, cic_ctrl, cic_datapath and cic_ram.
module cloud_in_cell_deposit_unit
    import cic_pkg::*;
#(
    parameter int MAX_CELLS_X = 32,
    parameter int MAX_CELLS_Y = 32,
    parameter int MAX_CELLS_Z = 32
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // pos_x[31:0], pos_y[63:32], pos_z[95:64], charge[127:96],
    // cell_index[142:128], zero pad[143]
    input  logic [S_TDATA_W-1:0]  s_tdata,
    input  logic                  s_tuser,   // opcode
    input  logic                  s_tlast,   // batch_end
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // read_value[47:0], status[49:48], zero pad[55:50]
    output logic [M_TDATA_W-1:0]  m_tdata,
    output logic                  m_tlast,   // batch_done
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);
    localparam int DEPTH  = MAX_CELLS_X * MAX_CELLS_Y * MAX_CELLS_Z;
    localparam int ADDR_W = $clog2(DEPTH);

    logic [SIZE_REG_W-1:0] size_x_reg, size_y_reg, size_z_reg;
    logic [INV_W-1:0]      inv_x_reg, inv_y_reg, inv_z_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            size_x_reg <= SIZE_REG_W'(32);
            size_y_reg <= SIZE_REG_W'(32);
            size_z_reg <= SIZE_REG_W'(32);
            inv_x_reg  <= INV_W'(65536);
            inv_y_reg  <= INV_W'(65536);
            inv_z_reg  <= INV_W'(65536);
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                CFG_SIZE_X: size_x_reg <= cfg_wdata[SIZE_REG_W-1:0];
                CFG_SIZE_Y: size_y_reg <= cfg_wdata[SIZE_REG_W-1:0];
                CFG_SIZE_Z: size_z_reg <= cfg_wdata[SIZE_REG_W-1:0];
                CFG_INV_X:  inv_x_reg  <= cfg_wdata;
                CFG_INV_Y:  inv_y_reg  <= cfg_wdata;
                CFG_INV_Z:  inv_z_reg  <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    cic_cmd_t          cmd;
    cic_sts_t          sts;
    logic              out_free;
    logic              ram_en, ram_we;
    logic [ADDR_W-1:0] ram_addr;
    logic [ACC_W-1:0]  ram_wdata, ram_rdata, res_value;
    logic [STAT_W-1:0] res_status;
    logic              res_done;

    logic                 m_tvalid_reg, m_tlast_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;

    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = cmd.in_ready;

    cic_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .out_free (out_free),
        .sts      (sts),
        .cmd      (cmd)
    );

    cic_datapath #(
        .MAX_CELLS_X (MAX_CELLS_X),
        .MAX_CELLS_Y (MAX_CELLS_Y),
        .MAX_CELLS_Z (MAX_CELLS_Z),
        .DEPTH       (DEPTH),
        .ADDR_W      (ADDR_W)
    ) u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .sts        (sts),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .s_tlast    (s_tlast),
        .size_x     (size_x_reg),
        .size_y     (size_y_reg),
        .size_z     (size_z_reg),
        .inv_x      (inv_x_reg),
        .inv_y      (inv_y_reg),
        .inv_z      (inv_z_reg),
        .ram_en     (ram_en),
        .ram_we     (ram_we),
        .ram_addr   (ram_addr),
        .ram_wdata  (ram_wdata),
        .ram_rdata  (ram_rdata),
        .res_value  (res_value),
        .res_status (res_status),
        .res_done   (res_done)
    );

    cic_ram #(
        .WIDTH (ACC_W),
        .DEPTH (DEPTH)
    ) u_grid (
        .aclk  (aclk),
        .en    (ram_en),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // output register: load a finished result, drop it once taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_tdata_reg <= {{(M_TDATA_W-ACC_W-STAT_W){1'b0}}, res_status, res_value};
            m_tlast_reg <= res_done;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    a_one_in_work: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("request accepted while another is in work");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!m_tvalid_reg || m_tready))
        else $error("result overwritten before it was taken");

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[ACC_W +: STAT_W] != 2'd3))
        else $error("undefined status code");

    a_read_no_batch: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[ACC_W +: STAT_W] == STAT_SAT) |-> (m_tdata[ACC_W-1:0] == '0))
        else $error("saturated deposit carries a read value");
endmodule

FILE: sv/cic_ram.sv
// Generic single-port RAM with registered read data.
// No dependencies.
module cic_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 32768
) (
    input  logic                     aclk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            if (we) begin
                mem[addr] <= wdata;
            end
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;
endmodule

FILE: sv/cic_ctrl.sv
// Sequencer for the deposit unit: clearing pass, item flow and corner loop.
// Depends on cic_pkg.
module cic_ctrl
    import cic_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_tvalid,
    input  logic     out_free,
    input  cic_sts_t sts,
    output cic_cmd_t cmd
);
    cic_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_CLEAR: begin
                cmd.clear = 1'b1;
                if (sts.clr_done) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                cmd.in_ready = 1'b1;
                if (s_tvalid) begin
                    cmd.accept = 1'b1;
                    state_next = ST_SPLIT;
                end
            end
            ST_SPLIT: begin
                cmd.split  = 1'b1;
                state_next = sts.is_read ? ST_RD_ADDR : ST_CHECK;
            end
            ST_CHECK: begin
                cmd.check  = 1'b1;
                state_next = sts.range_fail ? ST_FINISH : ST_C_ADDR;
            end
            ST_C_ADDR: begin
                cmd.c_addr = 1'b1;
                state_next = ST_C_WGT;
            end
            ST_C_WGT: begin
                cmd.c_wgt  = 1'b1;
                state_next = ST_C_READ;
            end
            ST_C_READ: begin
                cmd.c_read = 1'b1;
                state_next = ST_C_WRITE;
            end
            ST_C_WRITE: begin
                cmd.c_write = 1'b1;
                state_next  = sts.last_corner ? ST_FINISH : ST_C_ADDR;
            end
            ST_RD_ADDR: begin
                cmd.rd_addr = 1'b1;
                state_next  = ST_RD_DATA;
            end
            ST_RD_DATA: begin
                cmd.rd_data = 1'b1;
                state_next  = ST_FINISH;
            end
            ST_FINISH: begin
                // hold until the output register is free
                if (out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end
endmodule

FILE: sv/cic_datapath.sv
// Datapath: coordinate split, trilinear weights, corner addresses and the
// saturating read-modify-write on the grid memory. Depends on cic_pkg.
module cic_datapath
    import cic_pkg::*;
#(
    parameter int MAX_CELLS_X = 32,
    parameter int MAX_CELLS_Y = 32,
    parameter int MAX_CELLS_Z = 32,
    parameter int DEPTH       = MAX_CELLS_X * MAX_CELLS_Y * MAX_CELLS_Z,
    parameter int ADDR_W      = $clog2(DEPTH)
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  cic_cmd_t              cmd,
    output cic_sts_t              sts,
    input  logic [S_TDATA_W-1:0]  s_tdata,
    input  logic                  s_tuser,
    input  logic                  s_tlast,
    input  logic [SIZE_REG_W-1:0] size_x,
    input  logic [SIZE_REG_W-1:0] size_y,
    input  logic [SIZE_REG_W-1:0] size_z,
    input  logic [INV_W-1:0]      inv_x,
    input  logic [INV_W-1:0]      inv_y,
    input  logic [INV_W-1:0]      inv_z,
    output logic                  ram_en,
    output logic                  ram_we,
    output logic [ADDR_W-1:0]     ram_addr,
    output logic [ACC_W-1:0]      ram_wdata,
    input  logic [ACC_W-1:0]      ram_rdata,
    output logic [ACC_W-1:0]      res_value,
    output logic [STAT_W-1:0]     res_status,
    output logic                  res_done
);
    localparam int PX_LO = 0;
    localparam int PY_LO = POS_W;
    localparam int PZ_LO = 2 * POS_W;
    localparam int CH_LO = 3 * POS_W;
    localparam int IX_LO = 3 * POS_W + CHG_W;
    localparam int CELL_W = PROD_W - 2 * FRAC_W;
    localparam logic [WGT_W-1:0] ONE_Q16 = WGT_W'(1) << FRAC_W;

    logic [SZ_W-1:0] sx, sy, sz;
    assign sx = eff_size(size_x, SZ_W'(MAX_CELLS_X));
    assign sy = eff_size(size_y, SZ_W'(MAX_CELLS_Y));
    assign sz = eff_size(size_z, SZ_W'(MAX_CELLS_Z));

    // item registers
    logic                    op_reg, last_reg;
    logic [POS_W-1:0]        pos_x_reg, pos_y_reg, pos_z_reg;
    logic signed [CHG_W-1:0] chg_reg;
    logic [IDX_IN_W-1:0]     idx_reg;

    logic [PROD_W-1:0]       prod_x_reg, prod_y_reg, prod_z_reg;
    logic [2*SZ_W-1:0]       sxy_reg;
    logic [CI_W-1:0]         x0_reg, x1_reg, y0_reg, y1_reg, z0_reg, z1_reg;
    logic [WGT_W-1:0]        wx0_reg, wx1_reg, wy0_reg, wy1_reg, wz0_reg, wz1_reg;
    logic [WGT_W-1:0]        wxy_reg, w_reg;
    logic [16:0]             t_reg;
    logic [ADDR_W-1:0]       addr_reg;
    logic signed [CTRB_W-1:0] ctrb_reg;
    logic [ACC_W-1:0]        val_reg;
    logic                    oor_reg, sat_reg;
    logic [2:0]              corner_reg;
    logic [ADDR_W-1:0]       clr_cnt_reg;

    // cell and fraction per axis
    logic [CELL_W-1:0] cx, cy, cz;
    logic [FRAC_W-1:0] fx, fy, fz;
    logic              range_fail;
    assign cx = prod_x_reg[PROD_W-1:2*FRAC_W];
    assign cy = prod_y_reg[PROD_W-1:2*FRAC_W];
    assign cz = prod_z_reg[PROD_W-1:2*FRAC_W];
    assign fx = prod_x_reg[2*FRAC_W-1:FRAC_W];
    assign fy = prod_y_reg[2*FRAC_W-1:FRAC_W];
    assign fz = prod_z_reg[2*FRAC_W-1:FRAC_W];
    assign range_fail = (cx >= CELL_W'(sx)) || (cy >= CELL_W'(sy)) || (cz >= CELL_W'(sz));

    // upper neighbor wraps to cell 0 at the grid edge
    function automatic logic [CI_W-1:0] upper(logic [CI_W-1:0] c, logic [SZ_W-1:0] s);
        logic [SZ_W-1:0] n;
        n = SZ_W'(c) + SZ_W'(1);
        return (n == s) ? '0 : n[CI_W-1:0];
    endfunction

    // corner selection: x is the inner, z the outer loop
    logic [CI_W-1:0]  xi, yi, zi;
    logic [WGT_W-1:0] wxs, wys, wzs;
    assign xi  = corner_reg[0] ? x1_reg  : x0_reg;
    assign yi  = corner_reg[1] ? y1_reg  : y0_reg;
    assign zi  = corner_reg[2] ? z1_reg  : z0_reg;
    assign wxs = corner_reg[0] ? wx1_reg : wx0_reg;
    assign wys = corner_reg[1] ? wy1_reg : wy0_reg;
    assign wzs = corner_reg[2] ? wz1_reg : wz0_reg;

    logic [2*WGT_W-1:0]        wxy_prod, w_prod;
    logic [16:0]               t_calc;
    logic [24:0]               addr_calc;
    logic signed [CHG_W+WGT_W:0] q_prod;
    logic [26:0]               cells;
    assign wxy_prod  = wxs * wys;
    assign w_prod    = wxy_reg * wzs;
    assign t_calc    = 17'(zi * sy) + 17'(yi);
    assign addr_calc = 25'(t_reg * sx) + 25'(xi);
    assign q_prod    = chg_reg * $signed({1'b0, w_reg});
    assign cells     = 27'(sxy_reg * sz);

    // saturating accumulate
    logic [SUM_W-1:0] sum;
    logic             ovf;
    logic [ACC_W-1:0] acc_new;
    assign sum = {{2{ram_rdata[ACC_W-1]}}, ram_rdata}
               + {{(SUM_W-CTRB_W){ctrb_reg[CTRB_W-1]}}, ctrb_reg};
    assign ovf = (sum[SUM_W-1:ACC_W-1] != 3'b000) && (sum[SUM_W-1:ACC_W-1] != 3'b111);
    always_comb begin
        if (!ovf) begin
            acc_new = sum[ACC_W-1:0];
        end else if (sum[SUM_W-1]) begin
            acc_new = {1'b1, {(ACC_W-1){1'b0}}};
        end else begin
            acc_new = {1'b0, {(ACC_W-1){1'b1}}};
        end
    end

    // control-side registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_cnt_reg <= '0;
            corner_reg  <= '0;
            sat_reg     <= 1'b0;
            oor_reg     <= 1'b0;
        end else begin
            if (cmd.clear) begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            if (cmd.accept) begin
                corner_reg <= '0;
                sat_reg    <= 1'b0;
                oor_reg    <= 1'b0;
            end
            if (cmd.check) begin
                oor_reg <= range_fail;
            end
            if (cmd.rd_addr) begin
                oor_reg <= (27'(idx_reg) >= cells);
            end
            if (cmd.c_write) begin
                corner_reg <= corner_reg + 1'b1;
                if (ovf) begin
                    sat_reg <= 1'b1;
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            op_reg    <= s_tuser;
            last_reg  <= s_tlast;
            pos_x_reg <= s_tdata[PX_LO +: POS_W];
            pos_y_reg <= s_tdata[PY_LO +: POS_W];
            pos_z_reg <= s_tdata[PZ_LO +: POS_W];
            chg_reg   <= s_tdata[CH_LO +: CHG_W];
            idx_reg   <= s_tdata[IX_LO +: IDX_IN_W];
        end
        if (cmd.split) begin
            prod_x_reg <= pos_x_reg * inv_x;
            prod_y_reg <= pos_y_reg * inv_y;
            prod_z_reg <= pos_z_reg * inv_z;
            sxy_reg    <= sx * sy;
        end
        if (cmd.check) begin
            x0_reg  <= cx[CI_W-1:0];
            y0_reg  <= cy[CI_W-1:0];
            z0_reg  <= cz[CI_W-1:0];
            x1_reg  <= upper(cx[CI_W-1:0], sx);
            y1_reg  <= upper(cy[CI_W-1:0], sy);
            z1_reg  <= upper(cz[CI_W-1:0], sz);
            wx0_reg <= ONE_Q16 - WGT_W'(fx);
            wy0_reg <= ONE_Q16 - WGT_W'(fy);
            wz0_reg <= ONE_Q16 - WGT_W'(fz);
            wx1_reg <= WGT_W'(fx);
            wy1_reg <= WGT_W'(fy);
            wz1_reg <= WGT_W'(fz);
        end
        if (cmd.c_addr) begin
            wxy_reg <= wxy_prod[FRAC_W +: WGT_W];
            t_reg   <= t_calc;
        end
        if (cmd.c_wgt) begin
            w_reg    <= w_prod[FRAC_W +: WGT_W];
            addr_reg <= ADDR_W'(addr_calc);
        end
        if (cmd.c_read) begin
            ctrb_reg <= q_prod[CHG_W+WGT_W:FRAC_W];
        end
        if (cmd.rd_data) begin
            val_reg <= oor_reg ? '0 : ram_rdata;
        end
    end

    always_comb begin
        ram_en    = cmd.clear | cmd.rd_addr | cmd.c_read | cmd.c_write;
        ram_we    = cmd.clear | cmd.c_write;
        ram_wdata = cmd.clear ? '0 : acc_new;
        if (cmd.clear) begin
            ram_addr = clr_cnt_reg;
        end else if (cmd.rd_addr) begin
            ram_addr = ADDR_W'(idx_reg);
        end else begin
            ram_addr = addr_reg;
        end
    end

    assign sts.clr_done    = (clr_cnt_reg == ADDR_W'(DEPTH - 1));
    assign sts.is_read     = op_reg;
    assign sts.range_fail  = range_fail;
    assign sts.last_corner = (corner_reg == 3'd7);

    assign res_value  = op_reg ? val_reg : '0;
    assign res_status = oor_reg ? STAT_RANGE : (sat_reg ? STAT_SAT : STAT_OK);
    assign res_done   = op_reg ? 1'b0 : last_reg;
endmodule

FILE: test/cic_checker.sv
// Checker for the cloud-in-cell deposit unit: snoops the register port and both
// stream channels, keeps its own grid and register copies, and compares every
// response against the predicted one. Depends on cic_pkg.
module cic_checker
    import cic_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,
    input  logic                  s_tuser,
    input  logic                  s_tlast,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [M_TDATA_W-1:0]  m_tdata,
    input  logic                  m_tlast,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    output int                    fail_count,
    output int                    pending
);

    localparam int  GRID_DEPTH = 32 * 32 * 32;
    localparam int  DIM_MAX    = 32;
    localparam longint ACC_HI  = 64'sd140737488355327;
    localparam longint ACC_LO  = -64'sd140737488355328;

    typedef struct packed {
        logic [ACC_W-1:0] cell_value;
        cic_stat_t        status;
        logic             done;
    } cell_result_t;

    cell_result_t cell_results_q[$];
    longint grid_acc[GRID_DEPTH];
    logic [SIZE_REG_W-1:0] dim_reg[3];
    logic [INV_W-1:0]      inv_reg[3];

    function automatic int eff_dim(logic [SIZE_REG_W-1:0] r);
        if (r == 0) return 1;
        if (r > DIM_MAX) return DIM_MAX;
        return int'(r);
    endfunction

    function automatic cell_result_t predict_cell_read(logic [IDX_IN_W-1:0] idx);
        cell_result_t r;
        int cells;
        cells = eff_dim(dim_reg[0]) * eff_dim(dim_reg[1]) * eff_dim(dim_reg[2]);
        r = '0;
        if (idx >= cells) begin
            r.status = STAT_RANGE;
        end else begin
            r.status = STAT_OK;
            r.cell_value = grid_acc[idx][ACC_W-1:0];
        end
        return r;
    endfunction

    function automatic cell_result_t predict_deposit(logic [S_TDATA_W-1:0] d, logic last);
        cell_result_t r;
        int dim[3];
        int lo[3], hi[3];
        longint cidx[3], wt[3][2];
        logic [55:0] scaled;
        longint q, wxy, w, contrib, sum;
        int addr;
        bit sat;
        sat = 0;
        r = '0;
        r.done = last;
        r.status = STAT_OK;
        q = longint'(signed'(d[127:96]));
        for (int a = 0; a < 3; a++) begin
            dim[a] = eff_dim(dim_reg[a]);
            scaled = 56'(d[a*32 +: 32]) * 56'(inv_reg[a]);
            cidx[a] = longint'(scaled[55:32]);
            wt[a][1] = longint'(scaled[31:16]);
            wt[a][0] = 65536 - wt[a][1];
        end
        if (cidx[0] >= dim[0] || cidx[1] >= dim[1] || cidx[2] >= dim[2]) begin
            r.status = STAT_RANGE;
            return r;
        end
        for (int a = 0; a < 3; a++) begin
            lo[a] = int'(cidx[a]);
            hi[a] = (lo[a] + 1 == dim[a]) ? 0 : lo[a] + 1;
        end
        for (int c = 0; c < 2; c++)
            for (int b = 0; b < 2; b++)
                for (int a = 0; a < 2; a++) begin
                    wxy = (wt[0][a] * wt[1][b]) >> 16;
                    w = (wxy * wt[2][c]) >> 16;
                    contrib = (q * w) >>> 16;
                    addr = ((c ? hi[2] : lo[2]) * dim[1] + (b ? hi[1] : lo[1])) * dim[0]
                           + (a ? hi[0] : lo[0]);
                    sum = grid_acc[addr] + contrib;
                    if (sum > ACC_HI) begin
                        sum = ACC_HI;
                        sat = 1;
                    end else if (sum < ACC_LO) begin
                        sum = ACC_LO;
                        sat = 1;
                    end
                    grid_acc[addr] = sum;
                end
        if (sat) r.status = STAT_SAT;
        return r;
    endfunction

    initial begin
        fail_count = 0;
        pending = 0;
        for (int i = 0; i < GRID_DEPTH; i++) grid_acc[i] = 0;
    end

    always @(posedge aclk) begin
        cell_result_t got, want;
        if (!aresetn) begin
            for (int a = 0; a < 3; a++) begin
                dim_reg[a] = 6'd32;
                inv_reg[a] = 24'd65536;
            end
        end else begin
            if (cfg_wr_en) begin
                case (cfg_addr)
                    CFG_SIZE_X: dim_reg[0] = cfg_wdata[SIZE_REG_W-1:0];
                    CFG_SIZE_Y: dim_reg[1] = cfg_wdata[SIZE_REG_W-1:0];
                    CFG_SIZE_Z: dim_reg[2] = cfg_wdata[SIZE_REG_W-1:0];
                    CFG_INV_X:  inv_reg[0] = cfg_wdata;
                    CFG_INV_Y:  inv_reg[1] = cfg_wdata;
                    CFG_INV_Z:  inv_reg[2] = cfg_wdata;
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) begin
                got.cell_value = m_tdata[ACC_W-1:0];
                got.status = cic_stat_t'(m_tdata[ACC_W +: STAT_W]);
                got.done = m_tlast;
                if (cell_results_q.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected response: value %h status %0d done %b",
                                 got.cell_value, got.status, got.done);
                end else begin
                    want = cell_results_q.pop_front();
                    if (got !== want) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("mismatch: value %h/%h status %0d/%0d done %b/%b (exp/got)",
                                     want.cell_value, got.cell_value, want.status,
                                     got.status, want.done, got.done);
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                if (s_tuser)
                    cell_results_q.push_back(predict_cell_read(s_tdata[128 +: IDX_IN_W]));
                else
                    cell_results_q.push_back(predict_deposit(s_tdata, s_tlast));
            end
        end
        pending <= cell_results_q.size();
    end

endmodule

FILE: test/tb_cloud_in_cell_deposit_unit.sv
// Testbench top for the cloud-in-cell deposit unit: drives register writes,
// deposit and read requests with random gaps and stalls, and gives the verdict.
// Depends on cic_pkg, the unit's RTL and cic_checker.
module tb_cloud_in_cell_deposit_unit;
    import cic_pkg::*;

    localparam int LIMIT = 1000000;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd6;
    localparam logic OP_DEPOSIT = 1'b0;
    localparam logic OP_READ = 1'b1;

    logic                  aclk = 0;
    logic                  aresetn = 0;
    logic                  s_tvalid = 0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata = '0;
    logic                  s_tuser = 0;
    logic                  s_tlast = 0;
    logic                  m_tvalid;
    logic                  m_tready = 0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  m_tlast;
    logic                  cfg_wr_en = 0;
    logic [CFG_IDX_W-1:0]  cfg_addr = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    int fail_count, pending;
    int cycles = 0;
    bit quiet = 0;
    int stall_left = 0;
    int dim[3];
    longint inv[3];

    always #5 aclk = ~aclk;

    cloud_in_cell_deposit_unit uut (.*);
    cic_checker chk (.*);

    always @(posedge aclk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("cloud_in_cell_deposit_unit test failed");
            $finish;
        end
    end

    // Stall the response side in short bursts.
    always @(negedge aclk) begin
        if (quiet || !aresetn) begin
            m_tready = aresetn;
        end else if (stall_left > 0) begin
            stall_left--;
            m_tready = 0;
        end else if ($urandom_range(4, 0) == 0) begin
            stall_left = $urandom_range(3, 1) - 1;
            m_tready = 0;
        end else begin
            m_tready = 1;
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(negedge aclk);
        cfg_wr_en = 1;
        cfg_addr = idx;
        cfg_wdata = val;
        @(negedge aclk);
        cfg_wr_en = 0;
        case (idx)
            CFG_SIZE_X, CFG_SIZE_Y, CFG_SIZE_Z: begin
                dim[idx] = (val[5:0] == 0) ? 1 : (val[5:0] > 32) ? 32 : int'(val[5:0]);
            end
            CFG_INV_X, CFG_INV_Y, CFG_INV_Z: inv[idx - CFG_INV_X] = longint'(val);
            default: ;
        endcase
    endtask

    task automatic set_grid(int sx, int sy, int sz, int ix, int iy, int iz);
        write_reg(CFG_SIZE_X, CFG_DATA_W'(sx));
        write_reg(CFG_SIZE_Y, CFG_DATA_W'(sy));
        write_reg(CFG_SIZE_Z, CFG_DATA_W'(sz));
        write_reg(CFG_INV_X, CFG_DATA_W'(ix));
        write_reg(CFG_INV_Y, CFG_DATA_W'(iy));
        write_reg(CFG_INV_Z, CFG_DATA_W'(iz));
    endtask

    task automatic send_request(logic op, logic [31:0] px, logic [31:0] py, logic [31:0] pz,
                                logic [31:0] chg, logic [IDX_IN_W-1:0] idx, logic last);
        @(negedge aclk);
        if (!quiet && $urandom_range(3, 0) == 0) begin
            s_tvalid = 0;
            repeat ($urandom_range(3, 1)) @(negedge aclk);
        end
        s_tdata = {1'b0, idx, chg, pz, py, px};
        s_tuser = op;
        s_tlast = last;
        s_tvalid = 1;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic drain();
        @(negedge aclk);
        s_tvalid = 0;
        while (pending != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
    endtask

    // Position that mostly lands inside the grid for the current spacing.
    function automatic logic [31:0] pick_pos(int a);
        longint lim;
        if ($urandom_range(9, 0) == 0) return $urandom;
        lim = ((longint'(dim[a]) << 32) - 1) / inv[a];
        if (lim > 64'hFFFFFFFF) lim = 64'hFFFFFFFF;
        return $urandom_range(32'(lim), 0);
    endfunction

    function automatic logic [31:0] pick_charge();
        case ($urandom_range(9, 0))
            0: return 32'h7FFFFFFF;
            1: return 32'h80000000;
            default: return $urandom;
        endcase
    endfunction

    task automatic random_requests(int n);
        int cells;
        logic [IDX_IN_W-1:0] idx;
        for (int i = 0; i < n; i++) begin
            cells = dim[0] * dim[1] * dim[2];
            idx = ($urandom_range(9, 0) < 7) ? IDX_IN_W'($urandom_range(cells - 1, 0))
                                             : IDX_IN_W'($urandom);
            send_request(($urandom_range(3, 0) == 0) ? OP_READ : OP_DEPOSIT,
                         pick_pos(0), pick_pos(1), pick_pos(2), pick_charge(), idx,
                         $urandom_range(3, 0) == 0);
        end
    endtask

    initial begin
        dim = '{32, 32, 32};
        inv = '{65536, 65536, 65536};
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1;

        // Default grid: corners, extremes and the wrap at the top cell.
        send_request(OP_DEPOSIT, 0, 0, 0, 32'h7FFFFFFF, 0, 1);
        send_request(OP_DEPOSIT, 32'hFFFFFFFF, 0, 0, 32'h1000, 0, 0);
        send_request(OP_DEPOSIT, 32'h001F8000, 32'h001FC000, 32'h001F0001,
                     32'h80000000, 0, 1);
        send_request(OP_DEPOSIT, 32'h00010000, 32'h00020000, 32'h00030000, 0, 0, 0);
        send_request(OP_READ, 0, 0, 0, 0, 0, 1);
        send_request(OP_READ, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF,
                     32'hFFFFFFFF, 15'h7FFF, 0);
        send_request(OP_READ, 0, 0, 0, 0, 15'd31, 0);
        send_request(OP_READ, 0, 0, 0, 0, 15'd1023, 0);
        drain();

        // A 2x2x2 grid: heavy wrap, reads beyond the grid.
        set_grid(2, 2, 2, 65536, 65536, 65536);
        write_reg(CFG_UNUSED, 24'hFFFFFF);
        send_request(OP_DEPOSIT, 32'h00018000, 32'h00018000, 32'h0001FFFF, 32'h00010000, 0, 1);
        send_request(OP_DEPOSIT, 32'h00020000, 0, 0, 32'h00010000, 0, 0);
        send_request(OP_READ, 0, 0, 0, 0, 15'd7, 0);
        send_request(OP_READ, 0, 0, 0, 0, 15'd8, 1);
        send_request(OP_READ, 0, 0, 0, 0, 15'h7FFF, 0);
        random_requests(200);
        drain();

        set_grid(5, 7, 3, 24'hFFFFFF, 24'd1, 24'd300000);
        random_requests(250);
        drain();

        // Size zero acts as one, oversized acts as the maximum.
        set_grid(0, 63, 9, 24'd1, 24'd40000, 24'hFFFFFF);
        random_requests(250);
        drain();

        set_grid(32, 32, 32, $urandom_range(24'hFFFFFF, 1), $urandom_range(200000, 1),
                 $urandom_range(24'hFFFFFF, 1));
        random_requests(250);
        drain();

        set_grid(32, 32, 32, 65536, 65536, 65536);
        random_requests(500);
        quiet = 1;
        random_requests(200);
        drain();

        if (fail_count == 0 && pending == 0) begin
            $display("cloud_in_cell_deposit_unit test passed");
        end else begin
            $display("cloud_in_cell_deposit_unit test failed");
        end
        $finish;
    end

endmodule
